### hdl/dda_line_rasterizer_core_assert.svh
// Assertion macros shared by the rasterizer modules.
`ifndef DDA_LINE_RASTERIZER_CORE_ASSERT_SVH
`define DDA_LINE_RASTERIZER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DLR_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dda_line_rasterizer_core: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define DLR_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dda_line_rasterizer_core: assertion failed");

`endif

### hdl/dlr_pkg.sv
package dlr_pkg;

   localparam int DEF_SCREEN_WIDTH  = 1024;
   localparam int DEF_SCREEN_HEIGHT = 1024;
   localparam int DEF_FRAC_BITS     = 16;

   localparam int COORD_W    = 16;
   localparam int COLOR_W    = 24;
   localparam int ADDR_OUT_W = 24;
   localparam int BPP_W      = 4;
   localparam int STRIDE_W   = 16;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   localparam logic [BPP_W-1:0]    BPP_RESET    = 4'd4;
   localparam logic [STRIDE_W-1:0] STRIDE_RESET = 16'd4096;

   localparam logic [CSR_IDX_W-1:0] CSR_BYTES_PER_PIXEL = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LINE_STRIDE     = 1'd1;

   localparam logic CMD_START   = 1'b0;
   localparam logic CMD_ADVANCE = 1'b1;

   typedef struct packed {
      logic load_start;
      logic prep;
      logic div_start;
      logic commit_line;
      logic adv_capture;
      logic adv_multiply;
      logic out_load;
   } dlr_cmd_type;

   typedef struct packed {
      logic div_busy;
      logic div_done;
      logic out_free;
   } dlr_status_type;

endpackage

### hdl/dlr_div.sv
module dlr_div import dlr_pkg::*; #(
   parameter int N_W = 33,
   parameter int D_W = 17
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [N_W-1:0] dividend,
   input  logic [D_W-1:0] divisor,
   output logic           busy,
   output logic           done,
   output logic [N_W-1:0] quotient
);

   localparam int CNT_W = (N_W > 1) ? $clog2(N_W) : 1;

   logic [D_W-1:0]   rem_ff, rem_in;
   logic [N_W-1:0]   quo_ff, quo_in;
   logic [D_W-1:0]   dsr_ff, dsr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [D_W:0]     trial;
   logic             fits;

   // One quotient bit a cycle, restoring form; the dividend shifts out of the
   // top of the quotient register as the quotient shifts in at the bottom.
   assign trial = {rem_ff, quo_ff[N_W-1]};
   assign fits  = trial >= {1'b0, dsr_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dsr_in  = divisor;
         cnt_in  = CNT_W'(N_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? D_W'(trial - {1'b0, dsr_ff}) : trial[D_W-1:0];
         quo_in = {quo_ff[N_W-2:0], fits};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

### hdl/dlr_datapath.sv
`include "dda_line_rasterizer_core_assert.svh"

module dlr_datapath import dlr_pkg::*; #(
   parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
   parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT,
   parameter int FRAC_BITS     = DEF_FRAC_BITS
) (
   input  logic                       clock,
   input  logic                       reset,
   input  dlr_cmd_type                cmd,
   output dlr_status_type             status,
   input  logic signed [COORD_W-1:0]  req_start_x,
   input  logic signed [COORD_W-1:0]  req_start_y,
   input  logic signed [COORD_W-1:0]  req_end_x,
   input  logic signed [COORD_W-1:0]  req_end_y,
   input  logic [COLOR_W-1:0]         req_line_color,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [ADDR_OUT_W-1:0]      rsp_pixel_address,
   output logic [COLOR_W-1:0]         rsp_pixel_color,
   output logic                       rsp_write_enable,
   output logic                       rsp_idle,
   output logic                       rsp_last_pixel,
   input  logic                       csr_write_enable,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_write_data
);

   localparam int POS_W   = COORD_W + FRAC_BITS + 2;
   localparam int EXT_W   = POS_W - COORD_W - FRAC_BITS;
   localparam int DIFF_W  = COORD_W + 1;
   localparam int MAG_W   = DIFF_W;
   localparam int DVD_W   = MAG_W + FRAC_BITS;
   localparam int PIX_W   = POS_W - FRAC_BITS;
   localparam int CRD_W   = PIX_W + 1;
   localparam int XB      = $clog2(SCREEN_WIDTH);
   localparam int YB      = $clog2(SCREEN_HEIGHT);
   localparam int HALF_W  = SCREEN_WIDTH / 2;
   localparam int HALF_H  = SCREEN_HEIGHT / 2;
   localparam int XP_W    = XB + BPP_W;
   localparam int YP_W    = YB + STRIDE_W;
   localparam int SUM_W   = ((XP_W > YP_W) ? XP_W : YP_W) + 1;
   localparam int AREA    = SCREEN_WIDTH * SCREEN_HEIGHT;
   localparam int AREA_W  = $clog2(AREA + 1);
   localparam int LIM_W   = AREA_W + BPP_W;
   localparam int CMP_W   = ((SUM_W > LIM_W) ? SUM_W : LIM_W) + 1;

   // Configuration.
   logic [BPP_W-1:0]    bpp_ff;
   logic [STRIDE_W-1:0] stride_ff;

   // Line set-up.
   logic signed [DIFF_W-1:0] diff_x_ff, diff_x_in, diff_y_ff, diff_y_in;
   logic [MAG_W-1:0]         mag_x_ff, mag_x_in, mag_y_ff, mag_y_in;
   logic [MAG_W-1:0]         steps_ff, steps_in;
   logic                     neg_x_ff, neg_y_ff;
   logic [COLOR_W-1:0]       color_ff;
   logic [DVD_W-1:0]         quo_x, quo_y;
   logic                     busy_x, busy_y, done_x, done_y;

   // Line state.
   logic [POS_W-1:0]   pos_x_ff, pos_x_in, pos_y_ff, pos_y_in;
   logic [POS_W-1:0]   step_x_ff, step_x_in, step_y_ff, step_y_in;
   logic [MAG_W-1:0]   steps_left_ff, steps_left_in;
   logic               line_active_ff, line_active_in;

   // Advance pipeline.
   logic                    round_x, round_y;
   logic signed [PIX_W-1:0] pix_x, pix_y;
   logic signed [CRD_W-1:0] cx, cy;
   logic                    in_x, in_y, last_now;
   logic [XB-1:0]           a_cx_ff;
   logic [YB-1:0]           a_cy_ff;
   logic                    a_inwin_ff, a_active_ff, a_last_ff;
   logic [XP_W-1:0]         b_xp_ff;
   logic [YP_W-1:0]         b_yp_ff;
   logic [LIM_W-1:0]        b_lim_ff;
   logic [SUM_W-1:0]        sum;
   logic                    fits, we;

   // Result register.
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [ADDR_OUT_W-1:0] rsp_addr_ff;
   logic [COLOR_W-1:0]    rsp_color_ff;
   logic                  rsp_we_ff, rsp_idle_ff, rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bpp_ff    <= BPP_RESET;
         stride_ff <= STRIDE_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_BYTES_PER_PIXEL: bpp_ff    <= csr_write_data[BPP_W-1:0];
            CSR_LINE_STRIDE:     stride_ff <= csr_write_data[STRIDE_W-1:0];
            default: ;
         endcase
      end
   end

   // Set-up: differences on the start beat, then magnitudes and step count.
   assign diff_x_in = DIFF_W'(req_end_x) - DIFF_W'(req_start_x);
   assign diff_y_in = DIFF_W'(req_end_y) - DIFF_W'(req_start_y);
   assign mag_x_in  = diff_x_ff[DIFF_W-1] ? MAG_W'(-diff_x_ff) : MAG_W'(diff_x_ff);
   assign mag_y_in  = diff_y_ff[DIFF_W-1] ? MAG_W'(-diff_y_ff) : MAG_W'(diff_y_ff);
   assign steps_in  = (mag_x_in > mag_y_in) ? mag_x_in : mag_y_in;

   always_ff @(posedge clock) begin
      if (cmd.load_start) begin
         diff_x_ff <= diff_x_in;
         diff_y_ff <= diff_y_in;
         color_ff  <= req_line_color;
      end
      if (cmd.prep) begin
         mag_x_ff <= mag_x_in;
         mag_y_ff <= mag_y_in;
         steps_ff <= steps_in;
         neg_x_ff <= diff_x_ff[DIFF_W-1];
         neg_y_ff <= diff_y_ff[DIFF_W-1];
      end
   end

   dlr_div #(.N_W(DVD_W), .D_W(MAG_W)) u_div_x (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend ({mag_x_ff, {FRAC_BITS{1'b0}}}),
      .divisor  (steps_ff),
      .busy     (busy_x),
      .done     (done_x),
      .quotient (quo_x)
   );

   dlr_div #(.N_W(DVD_W), .D_W(MAG_W)) u_div_y (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend ({mag_y_ff, {FRAC_BITS{1'b0}}}),
      .divisor  (steps_ff),
      .busy     (busy_y),
      .done     (done_y),
      .quotient (quo_y)
   );

   // Pixel coordinate is the position truncated toward zero.
   assign round_x  = pos_x_ff[POS_W-1] & (|pos_x_ff[FRAC_BITS-1:0]);
   assign round_y  = pos_y_ff[POS_W-1] & (|pos_y_ff[FRAC_BITS-1:0]);
   assign pix_x    = pos_x_ff[POS_W-1:FRAC_BITS] + PIX_W'(round_x);
   assign pix_y    = pos_y_ff[POS_W-1:FRAC_BITS] + PIX_W'(round_y);
   assign cx       = CRD_W'(pix_x) + CRD_W'(HALF_W);
   assign cy       = CRD_W'(pix_y) + CRD_W'(HALF_H);
   assign in_x     = !cx[CRD_W-1] && (cx[CRD_W-2:0] < (CRD_W-1)'(SCREEN_WIDTH));
   assign in_y     = !cy[CRD_W-1] && (cy[CRD_W-2:0] < (CRD_W-1)'(SCREEN_HEIGHT));
   assign last_now = steps_left_ff <= MAG_W'(1);

   always_comb begin
      pos_x_in       = pos_x_ff;
      pos_y_in       = pos_y_ff;
      step_x_in      = step_x_ff;
      step_y_in      = step_y_ff;
      steps_left_in  = steps_left_ff;
      line_active_in = line_active_ff;
      if (cmd.load_start) begin
         pos_x_in = {{EXT_W{req_start_x[COORD_W-1]}}, req_start_x, {FRAC_BITS{1'b0}}};
         pos_y_in = {{EXT_W{req_start_y[COORD_W-1]}}, req_start_y, {FRAC_BITS{1'b0}}};
      end else if (cmd.commit_line) begin
         if (steps_ff == '0) begin
            step_x_in = '0;
            step_y_in = '0;
         end else begin
            step_x_in = neg_x_ff ? -POS_W'(quo_x) : POS_W'(quo_x);
            step_y_in = neg_y_ff ? -POS_W'(quo_y) : POS_W'(quo_y);
         end
         steps_left_in  = steps_ff + MAG_W'(1);
         line_active_in = 1'b1;
      end else if (cmd.adv_capture && line_active_ff) begin
         pos_x_in = pos_x_ff + step_x_ff;
         pos_y_in = pos_y_ff + step_y_ff;
         if (last_now) begin
            steps_left_in  = '0;
            line_active_in = 1'b0;
         end else begin
            steps_left_in = steps_left_ff - MAG_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      pos_x_ff  <= pos_x_in;
      pos_y_ff  <= pos_y_in;
      step_x_ff <= step_x_in;
      step_y_ff <= step_y_in;
      if (reset) begin
         steps_left_ff  <= '0;
         line_active_ff <= 1'b0;
      end else begin
         steps_left_ff  <= steps_left_in;
         line_active_ff <= line_active_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.adv_capture) begin
         a_cx_ff     <= cx[XB-1:0];
         a_cy_ff     <= cy[YB-1:0];
         a_inwin_ff  <= in_x && in_y;
         a_active_ff <= line_active_ff;
         a_last_ff   <= line_active_ff && last_now;
      end
      if (cmd.adv_multiply) begin
         b_xp_ff  <= XP_W'(a_cx_ff) * XP_W'(bpp_ff);
         b_yp_ff  <= YP_W'(a_cy_ff) * YP_W'(stride_ff);
         b_lim_ff <= LIM_W'(AREA) * LIM_W'(bpp_ff);
      end
   end

   // The pixel's last colour byte must still fall inside the buffer.
   assign sum  = SUM_W'(b_xp_ff) + SUM_W'(b_yp_ff);
   assign fits = (CMP_W'(sum) + CMP_W'(2)) < CMP_W'(b_lim_ff);
   assign we   = a_active_ff && a_inwin_ff && fits;

   assign rsp_valid_in = cmd.out_load ? 1'b1 : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (cmd.out_load) begin
         rsp_addr_ff  <= we ? ADDR_OUT_W'(sum) : '0;
         rsp_color_ff <= a_active_ff ? color_ff : '0;
         rsp_we_ff    <= we;
         rsp_idle_ff  <= !a_active_ff;
         rsp_last_ff  <= a_last_ff;
      end
   end

   assign status.div_busy = busy_x || busy_y;
   assign status.div_done = done_x && done_y;
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pixel_address = rsp_addr_ff;
   assign rsp_pixel_color   = rsp_color_ff;
   assign rsp_write_enable  = rsp_we_ff;
   assign rsp_idle          = rsp_idle_ff;
   assign rsp_last_pixel    = rsp_last_ff;

   `DLR_ASSERT_IMP(a_active_has_count, clock, reset, line_active_ff, steps_left_ff != '0)
   `DLR_ASSERT_IMP(a_write_not_idle, clock, reset, rsp_valid_ff && rsp_we_ff, !rsp_idle_ff)
   `DLR_ASSERT_IMP(a_idle_beat_clear, clock, reset, rsp_valid_ff && rsp_idle_ff,
      (rsp_addr_ff == '0) && (rsp_color_ff == '0) && !rsp_last_ff)

endmodule

### hdl/dlr_ctrl.sv
`include "dda_line_rasterizer_core_assert.svh"

module dlr_ctrl import dlr_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   input  logic           req_cmd,
   output logic           req_stall,
   output dlr_cmd_type    cmd,
   input  dlr_status_type status
);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_PREP     = 3'd1;
   localparam logic [2:0] S_DIV_GO   = 3'd2;
   localparam logic [2:0] S_DIV_WAIT = 3'd3;
   localparam logic [2:0] S_ADV_MUL  = 3'd4;
   localparam logic [2:0] S_ADV_OUT  = 3'd5;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_cmd == CMD_START) begin
                  cmd.load_start = 1'b1;
                  state_in       = S_PREP;
               end else begin
                  cmd.adv_capture = 1'b1;
                  state_in        = S_ADV_MUL;
               end
            end
         end
         S_PREP: begin
            cmd.prep = 1'b1;
            state_in = S_DIV_GO;
         end
         S_DIV_GO: begin
            cmd.div_start = 1'b1;
            state_in      = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (status.div_done) begin
               cmd.commit_line = 1'b1;
               state_in        = S_IDLE;
            end
         end
         S_ADV_MUL: begin
            cmd.adv_multiply = 1'b1;
            state_in         = S_ADV_OUT;
         end
         S_ADV_OUT: begin
            // Hold the finished pixel until the result register can take it.
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = state_ff != S_IDLE;

   `DLR_ASSERT_IMP(a_load_when_free, clock, reset, cmd.out_load, status.out_free)
   `DLR_ASSERT_IMP(a_wait_has_divider, clock, reset, state_ff == S_DIV_WAIT,
      status.div_busy || status.div_done)
   `DLR_ASSERT_NXT(a_start_runs_divider, clock, reset, cmd.div_start, status.div_busy)

endmodule

### hdl/dda_line_rasterizer_core.sv
// Channel   Handshake              Payload
// req       req_valid / req_stall  cmd, start_x, start_y, end_x, end_y, line_color
// rsp       rsp_valid / rsp_stall  pixel_address, pixel_color, write_enable, idle,
//                                   last_pixel
// csr       csr_write_enable       csr_index, csr_write_data (no read-back)
//
// A start beat passes PREP and DIV_GO, then waits in DIV_WAIT for the bit-serial
// dividers that form the per-step increments, one quotient bit a cycle.
// An advance beat goes through accept, the address multiply stage and result load.
// req_stall is high from acceptance until the beat is done. A stalled result waits in
// the output register while the next beat is taken; only the following result load
// waits for it. Reset is synchronous and clears the line and the registers to defaults.
module dda_line_rasterizer_core import dlr_pkg::*; #(
   parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
   parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT,
   parameter int FRAC_BITS     = DEF_FRAC_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_cmd,
   input  logic signed [COORD_W-1:0] req_start_x,
   input  logic signed [COORD_W-1:0] req_start_y,
   input  logic signed [COORD_W-1:0] req_end_x,
   input  logic signed [COORD_W-1:0] req_end_y,
   input  logic [COLOR_W-1:0]        req_line_color,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [ADDR_OUT_W-1:0]     rsp_pixel_address,
   output logic [COLOR_W-1:0]        rsp_pixel_color,
   output logic                      rsp_write_enable,
   output logic                      rsp_idle,
   output logic                      rsp_last_pixel,
   input  logic                      csr_write_enable,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_write_data
);

   dlr_cmd_type    cmd;
   dlr_status_type status;

   dlr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_cmd),
      .req_stall (req_stall),
      .cmd       (cmd),
      .status    (status)
   );

   dlr_datapath #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT),
      .FRAC_BITS     (FRAC_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_start_x       (req_start_x),
      .req_start_y       (req_start_y),
      .req_end_x         (req_end_x),
      .req_end_y         (req_end_y),
      .req_line_color    (req_line_color),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_pixel_address (rsp_pixel_address),
      .rsp_pixel_color   (rsp_pixel_color),
      .rsp_write_enable  (rsp_write_enable),
      .rsp_idle          (rsp_idle),
      .rsp_last_pixel    (rsp_last_pixel),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

endmodule
